>>> hw/rtl/lef_pkg.sv
// Shared constants and types of the Laplacian edge filter.
`timescale 1ns / 1ps

package lef_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_VALUE_BITS = 8;

    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int HUE_W        = 9;
    localparam int EDGE_W       = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int BORDER_W     = 8;
    localparam int MAX_HEIGHT   = 4096;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [BORDER_W-1:0]     RST_BORDER_VALUE = 8'd255;

    localparam logic [EDGE_W-1:0] EDGE_MAX = 12'h7FF;
    localparam logic [EDGE_W-1:0] EDGE_MIN = 12'h800;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BORDER_VALUE = 2'd2
    } lef_reg_t;

    // Row sits in the lowest bits, edge value in the highest.
    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic [HUE_W-1:0]  hue;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } lef_result_t;

    localparam int RESULT_W = $bits(lef_result_t);
    localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

    // Interior result goes out first, border result second.
    typedef struct packed {
        logic        int_valid;
        lef_result_t int_res;
        logic        bdr_valid;
        lef_result_t bdr_res;
    } lef_job_t;

endpackage

>>> hw/rtl/lef_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lef_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lef_front.sv
// Front end: pixel intake, raster position, line store, window and job build.
`timescale 1ns / 1ps

module lef_front
    import lef_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pix_valid,
    output logic                    pix_ready,
    input  logic [VALUE_BITS-1:0]   pix_value,
    input  logic [HUE_W-1:0]        pix_hue,
    input  logic [WIDTH_REG_W-1:0]  cfg_width,
    input  logic [HEIGHT_REG_W-1:0] cfg_height,
    input  logic [BORDER_W-1:0]     cfg_border,
    input  logic                    q_full,
    output logic                    q_push,
    output lef_job_t                q_job
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WCW   = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;
    localparam int EW    = VALUE_BITS + HUE_W;
    localparam int VW    = (VALUE_BITS > BORDER_W) ? VALUE_BITS : BORDER_W;
    localparam int SUM_W = VW + 5;
    localparam int XCW   = XW + COL_W;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(EDGE_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic [EDGE_W-1:0] sat_edge(input logic [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        s = $signed(v);
        if (s > SAT_HI) begin
            return EDGE_MAX;
        end else if (s < SAT_LO) begin
            return EDGE_MIN;
        end
        return v[EDGE_W-1:0];
    endfunction

    // raster position of the next pixel
    logic [XW-1:0]    x_reg;
    logic [ROW_W-1:0] y_reg;

    // stage A: accepted pixel waiting for its line store column
    logic                  a_valid_reg;
    logic [VALUE_BITS-1:0] a_value_reg;
    logic [HUE_W-1:0]      a_hue_reg;
    logic [XW-1:0]         a_x_reg;
    logic [ROW_W-1:0]      a_y_reg;
    logic                  a_lastc_reg;
    logic                  a_lastr_reg;
    logic                  a_fwd_reg;
    logic [2*EW-1:0]       a_fwd_data_reg;

    // window columns: mid holds column 0, new holds column 1 (the centre)
    logic [VALUE_BITS-1:0] win_mid_reg [3];
    logic [VALUE_BITS-1:0] win_new_reg [3];
    logic [HUE_W-1:0]      win_hue_reg;

    logic [WCW-1:0]          w_ext, w_eff, x_inc;
    logic [HEIGHT_REG_W-1:0] h_eff, y_inc;
    logic                    last_col, last_row;
    logic                    accept, a_go;
    logic [2*EW-1:0]         rd_word, col_word, wr_word;
    logic [EW-1:0]           col0, col1, cur;
    logic [SUM_W-1:0]        int_sum, bdr_sum;
    logic [XCW-1:0]          x_ext, xm1_ext;
    logic                    int_hit, bdr_hit;

    always_comb begin
        w_ext = WCW'(cfg_width);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (cfg_height == '0) begin
            h_eff = HEIGHT_REG_W'(1);
        end else if (cfg_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_eff = cfg_height;
        end
    end

    assign x_inc    = WCW'(x_reg) + WCW'(1);
    assign y_inc    = HEIGHT_REG_W'(y_reg) + HEIGHT_REG_W'(1);
    assign last_col = (x_inc >= w_eff);
    assign last_row = (y_inc >= h_eff);

    assign a_go      = a_valid_reg && !q_full;
    assign pix_ready = !a_valid_reg || a_go;
    assign accept    = pix_valid && pix_ready;

    // Line store: one word per column, low half is the older row.
    lef_ram #(
        .WIDTH (2 * EW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (a_go),
        .waddr (a_x_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (x_reg),
        .rdata (rd_word)
    );

    assign col_word = a_fwd_reg ? a_fwd_data_reg : rd_word;
    assign col0     = col_word[EW-1:0];
    assign col1     = col_word[2*EW-1:EW];
    assign cur      = {a_hue_reg, a_value_reg};
    assign wr_word  = {cur, col1};

    always_comb begin
        int_sum = SUM_W'(win_mid_reg[0]) + SUM_W'(win_mid_reg[1])
                + SUM_W'(win_mid_reg[2]) + SUM_W'(win_new_reg[0])
                + SUM_W'(win_new_reg[2]) + SUM_W'(col0[VALUE_BITS-1:0])
                + SUM_W'(col1[VALUE_BITS-1:0]) + SUM_W'(a_value_reg)
                - (SUM_W'(win_new_reg[1]) << 3);
        bdr_sum = (SUM_W'(cfg_border) << 3) - (SUM_W'(a_value_reg) << 3);
    end

    assign x_ext   = XCW'(a_x_reg);
    assign xm1_ext = x_ext - XCW'(1);
    assign int_hit = (a_x_reg >= XW'(2)) && (a_y_reg >= ROW_W'(2));
    assign bdr_hit = (a_x_reg == '0) || (a_y_reg == '0) || a_lastc_reg || a_lastr_reg;

    always_comb begin
        q_job.int_valid          = int_hit;
        q_job.int_res.row        = a_y_reg - ROW_W'(1);
        q_job.int_res.col        = xm1_ext[COL_W-1:0];
        q_job.int_res.hue        = win_hue_reg;
        q_job.int_res.edge_value = sat_edge(int_sum);
        q_job.bdr_valid          = bdr_hit;
        q_job.bdr_res.row        = a_y_reg;
        q_job.bdr_res.col        = x_ext[COL_W-1:0];
        q_job.bdr_res.hue        = a_hue_reg;
        q_job.bdr_res.edge_value = sat_edge(bdr_sum);
    end

    // drop jobs that carry no result
    assign q_push = a_go && (int_hit || bdr_hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            a_valid_reg <= 1'b0;
            a_fwd_reg   <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= 1'b1;
                if (last_col) begin
                    x_reg <= '0;
                    y_reg <= last_row ? '0 : y_inc[ROW_W-1:0];
                end else begin
                    x_reg <= x_inc[XW-1:0];
                end
                // the RAM returns stale data when the same column is written now
                a_fwd_reg <= a_go && (a_x_reg == x_reg);
            end else if (a_go) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_value_reg    <= pix_value;
            a_hue_reg      <= pix_hue;
            a_x_reg        <= x_reg;
            a_y_reg        <= y_reg;
            a_lastc_reg    <= last_col;
            a_lastr_reg    <= last_row;
            a_fwd_data_reg <= wr_word;
        end
        if (a_go) begin
            win_mid_reg    <= win_new_reg;
            win_new_reg[0] <= col0[VALUE_BITS-1:0];
            win_new_reg[1] <= col1[VALUE_BITS-1:0];
            win_new_reg[2] <= a_value_reg;
            win_hue_reg    <= col1[EW-1:VALUE_BITS];
        end
    end

endmodule

>>> hw/rtl/lef_queue.sv
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module lef_queue
    import lef_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lef_job_t push_job,
    output logic     full,
    input  logic     pop,
    output lef_job_t head_job,
    output logic     empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lef_job_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/lef_back.sv
// Output sequencer: splits each job into one or two result beats.
`timescale 1ns / 1ps

module lef_back
    import lef_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  lef_job_t         q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    logic        out_valid_reg;
    lef_result_t out_res_reg;
    logic        out_last_reg;
    logic        pend_valid_reg;
    lef_result_t pend_res_reg;
    logic        slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign q_pop     = slot_free && !pend_valid_reg && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (slot_free) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (!q_empty) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= q_head.int_valid && q_head.bdr_valid;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free) begin
            if (pend_valid_reg) begin
                out_res_reg  <= pend_res_reg;
                out_last_reg <= 1'b1;
            end else if (!q_empty) begin
                if (q_head.int_valid) begin
                    out_res_reg  <= q_head.int_res;
                    out_last_reg <= !q_head.bdr_valid;
                    pend_res_reg <= q_head.bdr_res;
                end else begin
                    out_res_reg  <= q_head.bdr_res;
                    out_last_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_res_reg);
    assign m_tlast  = out_last_reg;

endmodule

>>> hw/rtl/laplacian_edge_filter_top.sv
// Top level of the 3x3 Laplacian edge filter with its register port.
`timescale 1ns / 1ps

// Pixels enter in raster order at up to one beat per clock and each result
// carries its own row, column and hue. Interior pixel (y-1,x-1) comes out
// when pixel (y,x) is taken; a border pixel gives its result with its own
// beat, so a pixel in the right column or bottom row of an image can cause
// two result beats. The output port therefore sets the sustained rate: one
// pixel per clock while m_tready stays high and each pixel causes at most
// one beat. The results of a pixel pass through stage A, the job queue and
// the output register; a second beat waits in the pending register. The
// line store is a RAM of MAX_WIDTH words, one per column, holding the two
// previous rows; it needs no clearing after reset. Write image_width,
// image_height and border_value only while no beats are in flight.
module laplacian_edge_filter_top
    import lef_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // [VALUE_BITS-1:0] pixel_value, [VALUE_BITS+8:VALUE_BITS] pixel_hue
    input  logic [((VALUE_BITS + HUE_W + 7) / 8) * 8-1:0] s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // [11:0] out_row, [21:12] out_column, [30:22] out_hue, [42:31] edge_value
    output logic [OUT_W-1:0]                          m_tdata,
    output logic                                      m_tlast,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [3:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic [BORDER_W-1:0]     border_value_reg;
    logic                    cfg_write;

    logic     q_push, q_full, q_pop, q_empty;
    lef_job_t push_job, head_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            border_value_reg <= RST_BORDER_VALUE;
        end else if (cfg_write) begin
            unique case (lef_reg_t'(paddr[3:2]))
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HEIGHT_REG_W-1:0];
                REG_BORDER_VALUE: border_value_reg <= pwdata[BORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (lef_reg_t'(paddr[3:2]))
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            REG_BORDER_VALUE: prdata = 32'(border_value_reg);
            default:          prdata = '0;
        endcase
    end

    lef_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_valid  (s_tvalid),
        .pix_ready  (s_tready),
        .pix_value  (s_tdata[VALUE_BITS-1:0]),
        .pix_hue    (s_tdata[VALUE_BITS+HUE_W-1:VALUE_BITS]),
        .cfg_width  (image_width_reg),
        .cfg_height (image_height_reg),
        .cfg_border (border_value_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    lef_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    lef_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
